### src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared sizes and codes of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned MAX_FIRE = 16;

  localparam int unsigned SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_FIRE + 1);
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 20;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRY_W = TIME_W + VALUE_W;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_CREATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRAP  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

endpackage

`default_nettype wire

### src/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Store of pending millisecond timers with a time counter advanced by ticks.
// ----------------------------------------------------------------------------
// A create transfer stores the timer in the lowest free slot with deadline
// now plus delay and answers accepted, or rejected when all DEPTH slots are
// in use. A tick transfer advances time by one and then fires due timers,
// earliest deadline first, lower slot first on ties, up to MAX_FIRE per
// tick, with last set on the final one. Each fired timer costs one sweep of
// the slot RAM through a single subtract-and-compare unit; a tick with
// nothing due gives no result. Input is stalled while a tick is being worked
// on and while a result waits on a stalled output.
`default_nettype none

module deadline_timer_queue
  import dtq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [DELAY_W-1:0] delay_ms_i,
  input  logic [VALUE_W-1:0] user_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [VALUE_W-1:0] fired_value_o,
  output logic               last_o
);

  state_e             state_q, state_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [DEPTH-1:0]   slot_valid_q, slot_valid_d;

  logic [SLOT_W:0]    scan_q, scan_d;
  logic               cmp_pend_q, cmp_pend_d;
  logic [SLOT_W-1:0]  cmp_slot_q, cmp_slot_d;

  logic               best_found_q, best_found_d;
  logic [TIME_W-1:0]  best_key_q, best_key_d;
  logic [SLOT_W-1:0]  best_slot_q, best_slot_d;
  logic [VALUE_W-1:0] best_val_q, best_val_d;

  logic               pend_valid_q, pend_valid_d;
  logic [VALUE_W-1:0] pend_val_q, pend_val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         kind_q, kind_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               last_q, last_d;

  logic               out_free;
  logic               in_xfer;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  diff;
  logic [TIME_W-1:0]  key;
  logic               due;

  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .ADDR_W(SLOT_W)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_slot),
    .wdata_i(ram_wdata),
    .raddr_i(scan_q[SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign ram_we    = in_xfer && (cmd_i == CMD_CREATE) && free_found;
  assign ram_wdata = {now_q + TIME_W'(delay_ms_i), user_value_i};

  assign diff = ram_rdata[ENTRY_W-1:VALUE_W] - now_q;
  assign key  = diff ^ {1'b1, {(TIME_W-1){1'b0}}};
  assign due  = (diff == '0) || diff[TIME_W-1];

  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    slot_valid_d = slot_valid_q;
    scan_d       = scan_q;
    cmp_pend_d   = 1'b0;
    cmp_slot_d   = cmp_slot_q;
    best_found_d = best_found_q;
    best_key_d   = best_key_q;
    best_slot_d  = best_slot_q;
    best_val_d   = best_val_q;
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    value_d      = value_q;
    last_d       = last_q;

    // fold the slot read last cycle into the running minimum
    if (cmp_pend_q && slot_valid_q[cmp_slot_q] && due &&
        (!best_found_q || (key < best_key_q))) begin
      best_found_d = 1'b1;
      best_key_d   = key;
      best_slot_d  = cmp_slot_q;
      best_val_d   = ram_rdata[VALUE_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_i == CMD_CREATE) begin
            out_valid_d = 1'b1;
            value_d     = user_value_i;
            last_d      = 1'b1;
            if (free_found) begin
              kind_d                  = KIND_ACCEPT;
              slot_valid_d[free_slot] = 1'b1;
            end else begin
              kind_d = KIND_REJECT;
            end
          end else begin
            now_d        = now_q + TIME_W'(1);
            cnt_d        = '0;
            pend_valid_d = 1'b0;
            scan_d       = '0;
            best_found_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < (SLOT_W + 1)'(DEPTH)) begin
          cmp_pend_d = 1'b1;
          cmp_slot_d = scan_q[SLOT_W-1:0];
          scan_d     = scan_q + (SLOT_W + 1)'(1);
        end else if (!cmp_pend_q) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (best_found_q) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_FIRED;
              value_d     = pend_val_q;
              last_d      = 1'b0;
            end
            pend_valid_d              = 1'b1;
            pend_val_d                = best_val_q;
            slot_valid_d[best_slot_q] = 1'b0;
            cnt_d                     = cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(MAX_FIRE - 1)) begin
              state_d = ST_FLUSH;
            end else begin
              scan_d       = '0;
              best_found_d = 1'b0;
              state_d      = ST_SCAN;
            end
          end
        end else if (pend_valid_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          kind_d       = KIND_FIRED;
          value_d      = pend_val_q;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      now_q        <= '0;
      slot_valid_q <= '0;
      scan_q       <= '0;
      cmp_pend_q   <= 1'b0;
      best_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      slot_valid_q <= slot_valid_d;
      scan_q       <= scan_d;
      cmp_pend_q   <= cmp_pend_d;
      best_found_q <= best_found_d;
      pend_valid_q <= pend_valid_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_slot_q  <= cmp_slot_d;
    best_key_q  <= best_key_d;
    best_slot_q <= best_slot_d;
    best_val_q  <= best_val_d;
    pend_val_q  <= pend_val_d;
    kind_q      <= kind_d;
    value_q     <= value_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign fired_value_o = value_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

### tb/sv/deadline_timer_queue_test.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_test
// Self-checking testbench for the deadline timer queue.
// ----------------------------------------------------------------------------
// Drives create and tick transfers into the block with random gaps on the
// input side and random stalls on the result side. A scoreboard keeps its
// own copy of the time counter and the timer store, predicts every result
// in order and checks each accepted result field by field. A directed
// opening covers the empty tick, zero delay, equal deadlines, a full store
// and the widest delay and payload values; random episodes follow that fill
// and drain the store at varying create and tick mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module deadline_timer_queue_test;
  import dtq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_CYCLES  = (MAX_FIRE + 1) * (DEPTH + 3) + 50;
  localparam int unsigned RANDOM_ITEMS  = 185;
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned MAX_REPORTED  = 10;
  localparam int unsigned FAR_TIMER_CAP = 3;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } timer_result_t;

  class timer_scoreboard;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  deadline [DEPTH];
    logic [VALUE_W-1:0] payload [DEPTH];
    bit                 armed [DEPTH];
    timer_result_t      pending [$];
    int unsigned        creates, ticks, fired, rejected, results_seen, errors;

    function new();
      now_ms = '0;
      foreach (armed[i]) armed[i] = 1'b0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void note_input(cmd_e cmd, logic [DELAY_W-1:0] delay,
                             logic [VALUE_W-1:0] value);
      int                 best;
      int                 count;
      logic signed [31:0] gap_ms;
      logic signed [31:0] best_gap;
      logic [VALUE_W-1:0] burst [MAX_FIRE];
      if (cmd == CMD_CREATE) begin
        creates++;
        for (int i = 0; i < DEPTH; i++) begin
          if (!armed[i]) begin
            deadline[i] = now_ms + TIME_W'(delay);
            payload[i]  = value;
            armed[i]    = 1'b1;
            pending.push_back('{kind: KIND_ACCEPT, value: value, last: 1'b1});
            return;
          end
        end
        rejected++;
        pending.push_back('{kind: KIND_REJECT, value: value, last: 1'b1});
        return;
      end
      ticks++;
      now_ms = now_ms + 1;
      count  = 0;
      while (count < MAX_FIRE) begin
        best     = -1;
        best_gap = '0;
        for (int i = 0; i < DEPTH; i++) begin
          gap_ms = deadline[i] - now_ms;
          if (armed[i] && gap_ms <= 0 && (best < 0 || gap_ms < best_gap)) begin
            best     = i;
            best_gap = gap_ms;
          end
        end
        if (best < 0) break;
        armed[best]  = 1'b0;
        burst[count] = payload[best];
        count++;
      end
      fired += count;
      for (int k = 0; k < count; k++)
        pending.push_back('{kind: KIND_FIRED, value: burst[k], last: (k == count - 1)});
    endfunction

    function void check_result(logic [1:0] kind, logic [VALUE_W-1:0] value, logic last);
      timer_result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result kind %0d value %h last %0b",
                             kind, value, last));
        return;
      end
      exp = pending.pop_front();
      if (kind !== exp.kind || value !== exp.value || last !== exp.last)
        note_error($sformatf("result %0d expected kind %0d value %h last %0b, got %0d %h %0b",
                             results_seen, exp.kind, exp.value, exp.last,
                             kind, value, last));
    endfunction
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               cmd_i        = 1'b0;
  logic [DELAY_W-1:0] delay_ms_i   = '0;
  logic [VALUE_W-1:0] user_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [1:0]         kind_o;
  logic [VALUE_W-1:0] fired_value_o;
  logic               last_o;

  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int unsigned        cycle_count = 0;
  timer_scoreboard    sb;

  deadline_timer_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .delay_ms_i    (delay_ms_i),
    .user_value_i  (user_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .fired_value_o (fired_value_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b0)
      sb.note_input(cmd_e'(cmd_i), delay_ms_i, user_value_i);
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(kind_o, fired_value_o, last_o);
  end

  initial begin
    int unsigned hold;
    forever begin
      hold = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_ni && out_valid_o === 1'b1 && !out_stall_i));
    end
  end

  task automatic send_transfer(input cmd_e cmd, input logic [DELAY_W-1:0] delay,
                               input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    delay_ms_i   <= delay;
    user_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  initial begin
    int unsigned  sent;
    int unsigned  far_timers;
    int unsigned  create_pct;
    int unsigned  episode_len;
    int unsigned  roll;
    logic [1:0]   idle_mode;
    logic [DELAY_W-1:0] delay;

    sb         = new();
    sent       = 0;
    far_timers = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty tick, then reversed and equal deadlines with extreme payloads
    send_transfer(CMD_TICK,   '0, '0);
    send_transfer(CMD_CREATE, 20'd1, 32'h0000_0000);
    send_transfer(CMD_CREATE, 20'd0, 32'hFFFF_FFFF);
    send_transfer(CMD_CREATE, 20'd0, 32'h1234_5678);
    send_transfer(CMD_CREATE, 20'd1, 32'hA5A5_A5A5);
    send_transfer(CMD_TICK,   '0, '0);
    // fill the store, one far timer among them, then overflow it
    for (int i = 0; i < DEPTH; i++) begin
      delay = (i == 5) ? 20'hFFFFF : DELAY_W'(3 - (i % 4));
      send_transfer(CMD_CREATE, delay, $urandom);
    end
    send_transfer(CMD_CREATE, 20'd0, 32'h5A5A_5A5A);
    send_transfer(CMD_TICK,   '0, '0);
    send_transfer(CMD_TICK,   '0, '0);

    while (sent < RANDOM_ITEMS) begin
      create_pct  = $urandom_range(15, 85);
      episode_len = $urandom_range(10, 30);
      idle_mode   = 2'($urandom_range(0, 3));
      tx_idle     = idle_mode[0];
      rx_idle     = idle_mode[1];
      for (int k = 0; k < episode_len && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(1, 100) <= create_pct) begin
          roll = $urandom_range(0, 99);
          if (roll < 3 && far_timers < FAR_TIMER_CAP) begin
            delay = DELAY_W'($urandom);
            far_timers++;
          end else if (roll < 15) begin
            delay = DELAY_W'($urandom_range(0, 48));
          end else begin
            delay = DELAY_W'($urandom_range(0, 10));
          end
          send_transfer(CMD_CREATE, delay, $urandom);
        end else begin
          send_transfer(CMD_TICK, DELAY_W'($urandom), $urandom);
        end
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d creates (%0d rejected on a full store) and %0d ticks",
             sb.creates, sb.rejected, sb.ticks);
    $display("%0d timers fired, %0d results checked, %0d mismatches",
             sb.fired, sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### deadline_timer_queue.f
src/dtq_pkg.sv
src/dtq_ram.sv
src/deadline_timer_queue.sv
tb/sv/deadline_timer_queue_test.sv
